>>> rtl/obp_pkg.sv
// Package: sizes, codes and sequencer states for the online bin packer.
`default_nettype none

package obp_pkg;

   localparam int MAX_BINS    = 64;
   localparam int WEIGHT_BITS = 16;
   localparam int CAP_BITS    = 16;
   localparam int BIN_BITS    = $clog2(MAX_BINS);
   localparam int CNT_BITS    = $clog2(MAX_BINS + 1);
   localparam int SUM_BITS    = (WEIGHT_BITS + 1 > CAP_BITS) ? WEIGHT_BITS + 1 : CAP_BITS;

   // fit_mode register codes
   localparam logic [1:0] MODE_NEXT  = 2'd0;
   localparam logic [1:0] MODE_FIRST = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;
   localparam logic [1:0] MODE_BEST  = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_PLACED   = 2'd0;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // register indexes (address bit 2)
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_MODE     = 1'b1;

   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(100);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST,
      ST_SCAN,
      ST_COMMIT,
      ST_DONE
   } pack_state_type;

endpackage

`default_nettype wire

>>> rtl/obp_req_if.sv
// Interface: request channel carrying one item to place.
`default_nettype none

interface obp_req_if
   import obp_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [WEIGHT_BITS-1:0] item_weight;
   logic                   start_new_set;

   modport source (output valid, output item_weight, output start_new_set, input ready);
   modport sink   (input valid, input item_weight, input start_new_set, output ready);
endinterface

`default_nettype wire

>>> rtl/obp_rsp_if.sv
// Interface: response channel carrying the placement of one item.
`default_nettype none

interface obp_rsp_if
   import obp_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [BIN_BITS-1:0]    chosen_bin;
   logic [WEIGHT_BITS-1:0] new_fill;
   logic                   opened_bin;
   logic [CNT_BITS-1:0]    bins_in_use;
   logic [1:0]             status;

   modport source (output valid, output chosen_bin, output new_fill, output opened_bin,
                   output bins_in_use, output status, input ready);
   modport sink   (input valid, input chosen_bin, input new_fill, input opened_bin,
                   input bins_in_use, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/online_bin_packer.sv
// Top level: online bin packer with fill-level memory and a scanning sequencer.
//
//   channel  direction  handshake          payload
//   req_ch   in         valid/ready        item_weight, start_new_set
//   rsp_ch   out        valid/ready        chosen_bin, new_fill, opened_bin, bins_in_use, status
//   csr_*    in         APB write/read     bin_capacity (0x0), fit_mode (0x4)
//
// A request passes ST_IDLE, ST_LAST, ST_COMMIT and ST_DONE when no earlier bin is scanned (an
// oversize weight skips ST_COMMIT), with ST_SCAN before ST_COMMIT when earlier bins are scanned;
// the scan reads one fill level a cycle from the one-read one-write fill memory and tests it in
// the shared adder and comparator. Reset is synchronous; bin zero reads as empty after reset
// without a clearing pass. A new request is taken while a response still waits;
// the next response is held in the sequencer until the output register is free.
`default_nettype none

module online_bin_packer
   import obp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   obp_req_if.sink          req_ch,
   obp_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   pack_state_type         state_ff, state_in;
   logic [CAP_BITS-1:0]    cap_ff, cap_in;
   logic [1:0]             mode_ff, mode_in;
   logic [BIN_BITS-1:0]    last_bin_ff, last_bin_in;
   logic                   zero0_ff, zero0_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [BIN_BITS-1:0]    scan_ptr_ff, scan_ptr_in;
   logic                   found_ff, found_in;
   logic [BIN_BITS-1:0]    chosen_ff, chosen_in;
   logic [WEIGHT_BITS-1:0] best_fill_ff, best_fill_in;

   logic [BIN_BITS-1:0]    res_chosen_ff, res_chosen_in;
   logic [WEIGHT_BITS-1:0] res_fill_ff, res_fill_in;
   logic                   res_open_ff, res_open_in;
   logic [1:0]             res_status_ff, res_status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BIN_BITS-1:0]    rsp_chosen_ff, rsp_chosen_in;
   logic [WEIGHT_BITS-1:0] rsp_fill_ff, rsp_fill_in;
   logic                   rsp_open_ff, rsp_open_in;
   logic [CNT_BITS-1:0]    rsp_bins_ff, rsp_bins_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   // fill-level memory
   logic [WEIGHT_BITS-1:0] fill_mem [MAX_BINS];
   logic [BIN_BITS-1:0]    rd_addr;
   logic [BIN_BITS-1:0]    rd_idx_ff;
   logic [WEIGHT_BITS-1:0] rd_data_ff;
   logic                   wr_en;
   logic [BIN_BITS-1:0]    wr_addr;
   logic [WEIGHT_BITS-1:0] wr_data;

   // shared arithmetic
   logic [WEIGHT_BITS-1:0] fill_rd;
   logic [WEIGHT_BITS-1:0] add_a;
   logic [SUM_BITS-1:0]    add_sum;
   logic                   fits;
   logic                   oversize;
   logic                   fill_less;
   logic                   fill_more;
   logic                   accept;
   logic                   rsp_free;
   logic                   scan_last;
   logic                   commit_found;
   logic                   csr_write;

   // Handshakes
   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.chosen_bin  = rsp_chosen_ff;
   assign rsp_ch.new_fill    = rsp_fill_ff;
   assign rsp_ch.opened_bin  = rsp_open_ff;
   assign rsp_ch.bins_in_use = rsp_bins_ff;
   assign rsp_ch.status      = rsp_status_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_MODE) ? {30'b0, mode_ff}
                                                  : {{(32 - CAP_BITS){1'b0}}, cap_ff};

   // Bin zero reads as empty until it is first written after a reset or a new set
   assign fill_rd = (rd_idx_ff == '0 && zero0_ff) ? '0 : rd_data_ff;

   // Shared adder and comparators
   assign add_a     = (state_ff == ST_COMMIT) ? best_fill_ff : fill_rd;
   assign add_sum   = SUM_BITS'(add_a) + SUM_BITS'(weight_ff);
   assign fits      = (add_sum <= SUM_BITS'(cap_ff));
   assign oversize  = (SUM_BITS'(weight_ff) > SUM_BITS'(cap_ff));
   assign fill_less = (fill_rd < best_fill_ff);
   assign fill_more = (fill_rd > best_fill_ff);

   assign scan_last    = (rd_idx_ff == last_bin_ff - BIN_BITS'(1));
   assign commit_found = found_ff && fits;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LAST;
         end
         ST_LAST: begin
            if (oversize) state_in = ST_DONE;
            else if (fits) state_in = ST_COMMIT;
            else if (mode_ff != MODE_NEXT && last_bin_ff != '0) state_in = ST_SCAN;
            else state_in = ST_COMMIT;
         end
         ST_SCAN: begin
            if (mode_ff == MODE_FIRST && fits) state_in = ST_COMMIT;
            else if (scan_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      cap_in        = cap_ff;
      mode_in       = mode_ff;
      last_bin_in   = last_bin_ff;
      zero0_in      = zero0_ff;
      weight_in     = weight_ff;
      scan_ptr_in   = scan_ptr_ff;
      found_in      = found_ff;
      chosen_in     = chosen_ff;
      best_fill_in  = best_fill_ff;
      res_chosen_in = res_chosen_ff;
      res_fill_in   = res_fill_ff;
      res_open_in   = res_open_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_open_in   = rsp_open_ff;
      rsp_bins_in   = rsp_bins_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = chosen_ff;
      wr_data       = add_sum[WEIGHT_BITS-1:0];

      // take register writes
      if (csr_write) begin
         if (csr_paddr[2] == CSR_CAPACITY) cap_in = csr_pwdata[CAP_BITS-1:0];
         else mode_in = csr_pwdata[1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            // latch the request and read the last opened bin
            if (accept) begin
               weight_in = req_ch.item_weight;
               if (req_ch.start_new_set) begin
                  last_bin_in = '0;
                  zero0_in    = 1'b1;
               end
            end
            rd_addr = last_bin_in;
         end
         ST_LAST: begin
            found_in     = fits;
            chosen_in    = last_bin_ff;
            best_fill_in = fill_rd;
            scan_ptr_in  = BIN_BITS'(1);
            rd_addr      = '0;
            if (oversize) begin
               res_chosen_in = '0;
               res_fill_in   = '0;
               res_open_in   = 1'b0;
               res_status_in = STATUS_OVERSIZE;
            end else if (!fits) begin
               found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // issue the next read and test the bin that arrived
            rd_addr = scan_ptr_ff;
            if (scan_ptr_ff < last_bin_ff) scan_ptr_in = scan_ptr_ff + BIN_BITS'(1);
            unique case (mode_ff)
               MODE_FIRST: begin
                  if (fits && !found_ff) begin
                     found_in     = 1'b1;
                     chosen_in    = rd_idx_ff;
                     best_fill_in = fill_rd;
                  end
               end
               MODE_WORST: begin
                  if (!found_ff || fill_less) begin
                     found_in     = 1'b1;
                     chosen_in    = rd_idx_ff;
                     best_fill_in = fill_rd;
                  end
               end
               MODE_BEST: begin
                  if (fits && (!found_ff || fill_more)) begin
                     found_in     = 1'b1;
                     chosen_in    = rd_idx_ff;
                     best_fill_in = fill_rd;
                  end
               end
               default: begin
                  found_in = found_ff;
               end
            endcase
         end
         ST_COMMIT: begin
            // place in the chosen bin, open a new one, or report a full store
            if (commit_found) begin
               wr_en         = 1'b1;
               wr_addr       = chosen_ff;
               wr_data       = add_sum[WEIGHT_BITS-1:0];
               res_chosen_in = chosen_ff;
               res_fill_in   = add_sum[WEIGHT_BITS-1:0];
               res_open_in   = 1'b0;
               res_status_in = STATUS_PLACED;
               if (chosen_ff == '0) zero0_in = 1'b0;
            end else if (last_bin_ff == BIN_BITS'(MAX_BINS - 1)) begin
               res_chosen_in = '0;
               res_fill_in   = '0;
               res_open_in   = 1'b0;
               res_status_in = STATUS_FULL;
            end else begin
               last_bin_in   = last_bin_ff + BIN_BITS'(1);
               wr_en         = 1'b1;
               wr_addr       = last_bin_ff + BIN_BITS'(1);
               wr_data       = weight_ff;
               res_chosen_in = last_bin_ff + BIN_BITS'(1);
               res_fill_in   = weight_ff;
               res_open_in   = 1'b1;
               res_status_in = STATUS_PLACED;
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_chosen_in = res_chosen_ff;
               rsp_fill_in   = res_fill_ff;
               rsp_open_in   = res_open_ff;
               rsp_bins_in   = CNT_BITS'(last_bin_ff) + CNT_BITS'(1);
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // Fill-level memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) fill_mem[wr_addr] <= wr_data;
      rd_data_ff <= fill_mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAPACITY_RESET;
         mode_ff      <= MODE_NEXT;
         last_bin_ff  <= '0;
         zero0_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         mode_ff      <= mode_in;
         last_bin_ff  <= last_bin_in;
         zero0_ff     <= zero0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      weight_ff     <= weight_in;
      scan_ptr_ff   <= scan_ptr_in;
      found_ff      <= found_in;
      chosen_ff     <= chosen_in;
      best_fill_ff  <= best_fill_in;
      res_chosen_ff <= res_chosen_in;
      res_fill_ff   <= res_fill_in;
      res_open_ff   <= res_open_in;
      res_status_ff <= res_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_bins_ff   <= rsp_bins_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTHESIS
   // scan only runs over earlier bins
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (scan_ptr_ff <= last_bin_ff && last_bin_ff != '0))
      else $error("scan pointer beyond last opened bin");

   // an opened bin is the newest one
   a_open_newest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_open_ff |->
         (rsp_status_ff == STATUS_PLACED &&
          rsp_bins_ff == CNT_BITS'(rsp_chosen_ff) + CNT_BITS'(1)))
      else $error("opened bin is not the last bin");

   // a rejected request carries no placement
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_PLACED |->
         (rsp_chosen_ff == '0 && rsp_fill_ff == '0 && !rsp_open_ff))
      else $error("rejected response carries placement fields");

   // bins are only released by a new set, taken at acceptance
   a_last_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |=> last_bin_ff >= $past(last_bin_ff))
      else $error("last bin shrank during placement");
`endif

endmodule

`default_nettype wire
